// ===== rtl/kalman_cv_tracker_2d_macros.svh =====
// ----------------------------------------------------------------------------
// kalman_cv_tracker_2d_macros
// Assertion helpers used by the tracker sequencer. Clock and reset are the
// module's own clock and reset signals.
// ----------------------------------------------------------------------------
`ifndef KALMAN_CV_TRACKER_2D_MACROS_SVH
`define KALMAN_CV_TRACKER_2D_MACROS_SVH

// same-cycle implication
`define KCV_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("kcv assertion failed");

// next-cycle implication
`define KCV_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("kcv assertion failed");

`endif

// ===== rtl/kcv_pkg.sv =====
// ----------------------------------------------------------------------------
// kcv_pkg
// Types, constants and fixed-point helpers for the 2D constant-velocity
// Kalman tracker.
// ----------------------------------------------------------------------------
package kcv_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int DW         = 32;
   localparam int CSR_W      = 31;
   localparam int CSR_IDX_W  = 2;
   localparam int PROD_W     = 2 * DW;
   localparam int ACC_W      = PROD_W + 2;
   localparam int DET_W      = ACC_W - FRAC_BITS;
   localparam int DIV_W      = DW + FRAC_BITS + 1;
   localparam int DIV_CNT_W  = $clog2(DIV_W);

   localparam logic [1:0] OP_INIT    = 2'd0;
   localparam logic [1:0] OP_PREDICT = 2'd1;
   localparam logic [1:0] OP_UPDATE  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_Q_DIAG = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_R_DIAG = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_P_INIT = 2'd2;

   localparam logic [CSR_W-1:0] Q_RESET = CSR_W'(((1 << FRAC_BITS) + 500) / 1000);
   localparam logic [CSR_W-1:0] R_RESET = CSR_W'(((1 << FRAC_BITS) + 50) / 100);
   localparam logic [CSR_W-1:0] P_RESET = CSR_W'(1 << FRAC_BITS);

   localparam logic signed [DW-1:0]    ONE_Q    = DW'(64'sd1 << FRAC_BITS);
   localparam logic signed [ACC_W-1:0] HALF_ACC = ACC_W'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] ACC_MAX  = (ACC_W'(1) <<< (DW - 1)) - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] ACC_MIN  = -(ACC_W'(1) <<< (DW - 1));

   // state transition matrix, row major
   localparam logic AMAT [16] = '{1'b1, 1'b0, 1'b1, 1'b0,
                                  1'b0, 1'b1, 1'b0, 1'b1,
                                  1'b0, 1'b0, 1'b1, 1'b0,
                                  1'b0, 1'b0, 1'b0, 1'b1};

   // MAC element schedule: gain 0..7, state 8..11, covariance 12..27
   localparam logic [4:0] GAIN_END = 5'd8;
   localparam logic [4:0] X_END    = 5'd12;
   localparam logic [4:0] MAC_LAST = 5'd27;
   localparam logic [1:0] DIV_LAST = 2'd3;

   localparam logic [2:0] MS_BASE  = 3'd0;
   localparam logic [2:0] MS_MUL0  = 3'd1;
   localparam logic [2:0] MS_ACC0  = 3'd2;
   localparam logic [2:0] MS_MUL1  = 3'd3;
   localparam logic [2:0] MS_ACC1  = 3'd4;
   localparam logic [2:0] MS_STORE = 3'd5;

   typedef struct packed {
      logic [1:0]           opcode;
      logic signed [DW-1:0] meas_x;
      logic signed [DW-1:0] meas_y;
   } req_type;

   typedef struct packed {
      logic signed [DW-1:0] pos_x;
      logic signed [DW-1:0] pos_y;
      logic                 singular;
   } rsp_type;

   typedef struct packed {
      logic       accept;
      logic       det_mul0;
      logic       det_mul1;
      logic       det_sub;
      logic       det_store;
      logic       sing_set;
      logic       div_start;
      logic       div_store;
      logic [1:0] div_idx;
      logic       innov;
      logic       mac_en;
      logic [2:0] mac_sub;
      logic [4:0] mac_elem;
      logic       commit;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic det_pos;
      logic div_done;
   } sts_type;

   function automatic logic signed [DW-1:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [DW-1:0] r;
      if (v > ACC_MAX) begin
         r = {1'b0, {(DW-1){1'b1}}};
      end else if (v < ACC_MIN) begin
         r = {1'b1, {(DW-1){1'b0}}};
      end else begin
         r = v[DW-1:0];
      end
      return r;
   endfunction

   // round to nearest, ties up
   function automatic logic signed [ACC_W-1:0] rnd(input logic signed [PROD_W-1:0] p);
      logic signed [ACC_W-1:0] t;
      t = ACC_W'(p) + HALF_ACC;
      return t >>> FRAC_BITS;
   endfunction

endpackage

// ===== rtl/kcv_div.sv =====
// ----------------------------------------------------------------------------
// kcv_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kcv_div import kcv_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] quotient
);

   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIV_W-1:0]     den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_W:0]       trial;
   logic                 fits;

   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
         cnt_in  = DIV_CNT_W'(DIV_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? DIV_W'(trial - {1'b0, den_ff}) : trial[DIV_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/kcv_dp.sv =====
// ----------------------------------------------------------------------------
// kcv_dp
// Tracker datapath: state and covariance registers, config registers, one
// shared 32x32 multiplier with accumulator, inverse divider, result word.
// ----------------------------------------------------------------------------
module kcv_dp import kcv_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output sts_type              sts,
   input  req_type              req_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DW-1:0]        csr_wdata,
   output rsp_type              rsp_data
);

   logic [CSR_W-1:0]        q_ff, r_ff, p_ff;
   logic signed [DW-1:0]    x_ff    [4];
   logic signed [DW-1:0]    cov_ff  [16];
   logic signed [DW-1:0]    np_ff   [16];
   logic signed [DW-1:0]    gain_ff [8];
   logic signed [DW-1:0]    inv_ff  [4];
   logic signed [DW-1:0]    e_ff    [2];
   logic signed [DW-1:0]    mx_ff, my_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [DET_W-1:0] det_ff;
   logic                    sing_ff;
   logic                    neg_ff;
   rsp_type                 rsp_ff;

   logic signed [DW-1:0]    s00, s01, s10, s11;
   logic signed [DW-1:0]    pred_cov [16];
   logic signed [DW-1:0]    mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_p;

   logic                    is_gain, is_x, is_p, term;
   logic [1:0]              xi, gi, pi, pj;
   logic                    col;
   logic [3:0]              pe, cov_addr;
   logic [2:0]              gain_addr;
   logic signed [DW-1:0]    cov_rd, gain_rd, op_a, op_b;
   logic signed [ACC_W-1:0] base, term_val, mac_sum;
   logic signed [DW-1:0]    mac_res;

   logic signed [DW:0]      cof;
   logic [DW:0]             mag;
   logic [DIV_W-1:0]        dividend;
   logic                    div_done;
   logic [DIV_W-1:0]        quotient;
   logic signed [ACC_W-1:0] inv_val;

   logic                    acc_op, mac_mul;

   // innovation covariance
   assign s00 = sat32(ACC_W'(cov_ff[0]) + ACC_W'(r_ff));
   assign s11 = sat32(ACC_W'(cov_ff[5]) + ACC_W'(r_ff));
   assign s01 = cov_ff[1];
   assign s10 = cov_ff[4];

   // prediction P = A P A' + Q
   always_comb begin
      logic signed [ACC_W-1:0] pacc;
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            pacc = (i == j) ? ACC_W'(q_ff) : '0;
            for (int k = 0; k < 4; k++) begin
               for (int l = 0; l < 4; l++) begin
                  if (AMAT[i*4+k] && AMAT[j*4+l]) begin
                     pacc = pacc + ACC_W'(cov_ff[k*4+l]);
                  end
               end
            end
            pred_cov[i*4+j] = sat32(pacc);
         end
      end
   end

   // MAC element decode
   assign is_gain  = cmd.mac_elem < GAIN_END;
   assign is_x     = !is_gain && (cmd.mac_elem < X_END);
   assign is_p     = !is_gain && !is_x;
   assign term     = (cmd.mac_sub == MS_MUL1) || (cmd.mac_sub == MS_ACC1);
   assign xi       = cmd.mac_elem[1:0];
   assign gi       = cmd.mac_elem[2:1];
   assign col      = cmd.mac_elem[0];
   assign pe       = 4'(cmd.mac_elem - X_END);
   assign pi       = pe[3:2];
   assign pj       = pe[1:0];
   assign cov_addr = (cmd.mac_sub == MS_BASE) ? pe :
                     is_gain ? {gi, 1'b0, term} : {1'b0, term, pj};
   assign gain_addr = {(is_x ? xi : pi), term};
   assign cov_rd   = cov_ff[cov_addr];
   assign gain_rd  = gain_ff[gain_addr];
   assign op_a     = is_gain ? cov_rd : gain_rd;
   assign op_b     = is_gain ? inv_ff[{term, col}] : (is_x ? e_ff[term] : cov_rd);
   assign base     = is_gain ? '0 : (is_x ? ACC_W'(x_ff[xi]) : ACC_W'(cov_rd));
   assign term_val = rnd(prod_ff);
   assign mac_sum  = is_p ? acc_ff - term_val : acc_ff + term_val;
   assign mac_res  = sat32(acc_ff);

   assign acc_op  = cmd.mac_en && ((cmd.mac_sub == MS_ACC0) || (cmd.mac_sub == MS_ACC1));
   assign mac_mul = cmd.mac_en && ((cmd.mac_sub == MS_MUL0) || (cmd.mac_sub == MS_MUL1));

   // shared multiplier
   always_comb begin
      mul_a = s00;
      mul_b = s11;
      if (cmd.det_mul1) begin
         mul_a = s01;
         mul_b = s10;
      end else if (cmd.mac_en) begin
         mul_a = op_a;
         mul_b = op_b;
      end
   end
   assign mul_p = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (cmd.det_mul0 || cmd.det_mul1 || mac_mul) begin
         prod_ff <= mul_p;
      end
      if (cmd.det_mul1) begin
         acc_ff <= ACC_W'(prod_ff);
      end else if (cmd.det_sub) begin
         acc_ff <= acc_ff - ACC_W'(prod_ff);
      end else if (cmd.mac_en && (cmd.mac_sub == MS_BASE)) begin
         acc_ff <= base;
      end else if (acc_op) begin
         acc_ff <= mac_sum;
      end
      if (cmd.det_store) begin
         det_ff <= DET_W'((acc_ff + HALF_ACC) >>> FRAC_BITS);
      end
   end

   assign sts.det_pos = !det_ff[DET_W-1] && (det_ff != '0);

   // inverse of S, one cofactor per division
   always_comb begin
      unique case (cmd.div_idx)
         2'd0:    cof = (DW+1)'(s11);
         2'd1:    cof = -((DW+1)'(s01));
         2'd2:    cof = -((DW+1)'(s10));
         default: cof = (DW+1)'(s00);
      endcase
   end
   assign mag      = cof[DW] ? -cof : cof;
   assign dividend = (DIV_W'(mag) << FRAC_BITS) + (DIV_W'(det_ff) >> 1);

   kcv_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (DIV_W'(det_ff)),
      .done     (div_done),
      .quotient (quotient)
   );

   assign sts.div_done = div_done;
   assign inv_val = neg_ff ? -ACC_W'(quotient) : ACC_W'(quotient);

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         neg_ff <= cof[DW];
      end
      if (cmd.div_store) begin
         inv_ff[cmd.div_idx] <= sat32(inv_val);
      end
      if (cmd.innov) begin
         e_ff[0] <= sat32(ACC_W'(mx_ff) - ACC_W'(x_ff[0]));
         e_ff[1] <= sat32(ACC_W'(my_ff) - ACC_W'(x_ff[1]));
      end
      if (cmd.mac_en && (cmd.mac_sub == MS_STORE)) begin
         if (is_gain) begin
            gain_ff[cmd.mac_elem[2:0]] <= mac_res;
         end
         if (is_p) begin
            np_ff[pe] <= mac_res;
         end
      end
      if (cmd.accept) begin
         mx_ff   <= req_data.meas_x;
         my_ff   <= req_data.meas_y;
         sing_ff <= 1'b0;
      end else if (cmd.sing_set) begin
         sing_ff <= 1'b1;
      end
      if (cmd.rsp_load) begin
         rsp_ff.pos_x    <= x_ff[0];
         rsp_ff.pos_y    <= x_ff[1];
         rsp_ff.singular <= sing_ff;
      end
   end

   // track state and covariance
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            x_ff[i] <= '0;
         end
         for (int i = 0; i < 16; i++) begin
            cov_ff[i] <= (i % 5 == 0) ? ONE_Q : '0;
         end
      end else begin
         if (cmd.accept && (req_data.opcode == OP_INIT)) begin
            x_ff[0] <= req_data.meas_x;
            x_ff[1] <= req_data.meas_y;
            x_ff[2] <= '0;
            x_ff[3] <= '0;
            for (int i = 0; i < 16; i++) begin
               cov_ff[i] <= (i % 5 == 0) ? DW'(p_ff) : '0;
            end
         end else if (cmd.accept && (req_data.opcode == OP_PREDICT)) begin
            x_ff[0] <= sat32(ACC_W'(x_ff[0]) + ACC_W'(x_ff[2]));
            x_ff[1] <= sat32(ACC_W'(x_ff[1]) + ACC_W'(x_ff[3]));
            cov_ff  <= pred_cov;
         end else if (cmd.commit) begin
            cov_ff <= np_ff;
         end else if (cmd.mac_en && (cmd.mac_sub == MS_STORE) && is_x) begin
            x_ff[xi] <= mac_res;
         end
      end
   end

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff <= Q_RESET;
         r_ff <= R_RESET;
         p_ff <= P_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_Q_DIAG) begin
            q_ff <= csr_wdata[CSR_W-1:0];
         end
         if (csr_index == CSR_R_DIAG) begin
            r_ff <= csr_wdata[CSR_W-1:0];
         end
         if (csr_index == CSR_P_INIT) begin
            p_ff <= csr_wdata[CSR_W-1:0];
         end
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== rtl/kcv_ctrl.sv =====
// ----------------------------------------------------------------------------
// kcv_ctrl
// Tracker sequencer: handshakes, determinant, four divisions, the MAC
// schedule for gain, state and covariance, and the result word.
// ----------------------------------------------------------------------------
`include "kalman_cv_tracker_2d_macros.svh"

module kcv_ctrl import kcv_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_opcode,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  sts_type    sts,
   output cmd_type    cmd
);

   typedef enum logic [11:0] {
      ST_IDLE     = 12'b0000_0000_0001,
      ST_DET_A    = 12'b0000_0000_0010,
      ST_DET_B    = 12'b0000_0000_0100,
      ST_DET_C    = 12'b0000_0000_1000,
      ST_DET_D    = 12'b0000_0001_0000,
      ST_CHECK    = 12'b0000_0010_0000,
      ST_DIV_GO   = 12'b0000_0100_0000,
      ST_DIV_WAIT = 12'b0000_1000_0000,
      ST_INNOV    = 12'b0001_0000_0000,
      ST_MAC      = 12'b0010_0000_0000,
      ST_COMMIT   = 12'b0100_0000_0000,
      ST_DONE     = 12'b1000_0000_0000
   } state_type;

   state_type  state_ff, state_in;
   logic [4:0] elem_ff, elem_in;
   logic [2:0] sub_ff, sub_in;
   logic [1:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      elem_in      = elem_ff;
      sub_in       = sub_ff;
      idx_in       = idx_ff;
      cmd          = '0;
      cmd.mac_sub  = sub_ff;
      cmd.mac_elem = elem_ff;
      cmd.div_idx  = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.accept = 1'b1;
               state_in   = (req_opcode == OP_UPDATE) ? ST_DET_A : ST_DONE;
            end
         end
         ST_DET_A: begin
            cmd.det_mul0 = 1'b1;
            state_in     = ST_DET_B;
         end
         ST_DET_B: begin
            cmd.det_mul1 = 1'b1;
            state_in     = ST_DET_C;
         end
         ST_DET_C: begin
            cmd.det_sub = 1'b1;
            state_in    = ST_DET_D;
         end
         ST_DET_D: begin
            cmd.det_store = 1'b1;
            state_in      = ST_CHECK;
         end
         ST_CHECK: begin
            if (sts.det_pos) begin
               idx_in   = '0;
               state_in = ST_DIV_GO;
            end else begin
               cmd.sing_set = 1'b1;
               state_in     = ST_DONE;
            end
         end
         ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (sts.div_done) begin
               cmd.div_store = 1'b1;
               if (idx_ff == DIV_LAST) begin
                  state_in = ST_INNOV;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_DIV_GO;
               end
            end
         end
         ST_INNOV: begin
            cmd.innov = 1'b1;
            elem_in   = '0;
            sub_in    = MS_BASE;
            state_in  = ST_MAC;
         end
         ST_MAC: begin
            cmd.mac_en = 1'b1;
            if (sub_ff == MS_STORE) begin
               sub_in = MS_BASE;
               if (elem_ff == MAC_LAST) begin
                  state_in = ST_COMMIT;
               end else begin
                  elem_in = elem_ff + 1'b1;
               end
            end else begin
               sub_in = sub_ff + 1'b1;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         elem_ff      <= '0;
         sub_ff       <= MS_BASE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         elem_ff      <= elem_in;
         sub_ff       <= sub_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `KCV_ASSERT_NEXT(a_upd_to_det, accept && (req_opcode == OP_UPDATE), state_ff == ST_DET_A)
   `KCV_ASSERT_NEXT(a_div_no_early_done, cmd.div_start, !sts.div_done)
   `KCV_ASSERT_SAME(a_load_slot_free, cmd.rsp_load, !rsp_valid_ff || rsp_ready)
   `KCV_ASSERT_SAME(a_mac_range, state_ff == ST_MAC, (elem_ff <= MAC_LAST) && (sub_ff <= MS_STORE))

endmodule

// ===== rtl/kalman_cv_tracker_2d.sv =====
// ----------------------------------------------------------------------------
// kalman_cv_tracker_2d
// Single-object 4-state constant-velocity Kalman tracker, Q16.16 fixed point.
//
// channel  direction  word         handshake
// req_     in         req_type     req_valid / req_ready
// rsp_     out        rsp_type     rsp_valid / rsp_ready
// csr_     in         index, data  csr_valid / csr_ready (always ready)
//
// Init and predict: from accept straight to the done state, which loads the result.
// Update: four 49-step divider runs for S^-1, then 56 products through the
// single shared multiplier (base, mul, acc, mul, acc, store per element).
// A singular update goes from the determinant check straight to the done state.
// A new word is taken once the previous result is in the output register.
// Reset restores default registers, zero state and identity covariance.
// ----------------------------------------------------------------------------
module kalman_cv_tracker_2d import kcv_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DW-1:0]        csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   kcv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_data.opcode),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   kcv_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the 2D constant-velocity Kalman tracker against a fixed-point
// predictor of the filter. A queue-fed driver sends init, predict, update and
// unused-opcode words with random idling, a monitor compares every result word
// with the oldest predicted position and singular flag. Noise and covariance
// registers are changed between phases while the tracker is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
   import kcv_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DW-1:0]        csr_wdata;
   logic                 req_ready_q;

   kalman_cv_tracker_2d dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // filter model state
   longint    q_val, r_val, p_val;
   int signed trk [4];
   int signed cov [16];

   req_type pending_words [$];
   rsp_type expected_pos [$];
   int      mismatches;
   int      results_seen;
   int      cycles;
   int      updates_ok, updates_sing;
   bit      idle_on;
   bit      csr_busy;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int signed clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
   endfunction

   // round to nearest, ties up; >>> is an arithmetic floor
   function automatic longint qmul(int signed a, int signed b);
      longint p;
      p = longint'(a) * longint'(b) + (64'sd1 <<< (FRAC_BITS - 1));
      return p >>> FRAC_BITS;
   endfunction

   function automatic longint div_away(longint num, longint den);
      longint mag, q;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -q : q;
   endfunction

   task automatic filter_reset();
      q_val = Q_RESET;
      r_val = R_RESET;
      p_val = P_RESET;
      foreach (trk[i]) trk[i] = 0;
      foreach (cov[i]) cov[i] = (i % 5 == 0) ? (1 <<< FRAC_BITS) : 0;
   endtask

   task automatic filter_step(req_type w, output rsp_type r);
      int signed np [16];
      int signed s00, s01, s10, s11, e0, e1;
      int signed inv [4];
      int signed gn [8];
      longint det, acc;
      bit sing;
      sing = 1'b0;
      case (w.opcode)
         OP_INIT: begin
            trk[0] = w.meas_x;
            trk[1] = w.meas_y;
            trk[2] = 0;
            trk[3] = 0;
            foreach (cov[i]) cov[i] = (i % 5 == 0) ? int'(p_val) : 0;
         end
         OP_PREDICT: begin
            trk[0] = clamp32(longint'(trk[0]) + trk[2]);
            trk[1] = clamp32(longint'(trk[1]) + trk[3]);
            for (int i = 0; i < 4; i++)
               for (int j = 0; j < 4; j++) begin
                  acc = (i == j) ? q_val : 0;
                  for (int k = 0; k < 4; k++)
                     for (int l = 0; l < 4; l++)
                        if (AMAT[i*4+k] && AMAT[j*4+l]) acc += cov[k*4+l];
                  np[i*4+j] = clamp32(acc);
               end
            cov = np;
         end
         OP_UPDATE: begin
            s00 = clamp32(longint'(cov[0]) + r_val);
            s01 = cov[1];
            s10 = cov[4];
            s11 = clamp32(longint'(cov[5]) + r_val);
            det = (longint'(s00) * s11 - longint'(s01) * s10
                   + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            if (det <= 0) begin
               sing = 1'b1;
            end else begin
               inv[0] = clamp32(div_away(longint'(s11) <<< FRAC_BITS, det));
               inv[1] = clamp32(div_away(-(longint'(s01) <<< FRAC_BITS), det));
               inv[2] = clamp32(div_away(-(longint'(s10) <<< FRAC_BITS), det));
               inv[3] = clamp32(div_away(longint'(s00) <<< FRAC_BITS, det));
               for (int i = 0; i < 4; i++) begin
                  gn[i*2]   = clamp32(qmul(cov[i*4], inv[0]) + qmul(cov[i*4+1], inv[2]));
                  gn[i*2+1] = clamp32(qmul(cov[i*4], inv[1]) + qmul(cov[i*4+1], inv[3]));
               end
               e0 = clamp32(longint'(w.meas_x) - trk[0]);
               e1 = clamp32(longint'(w.meas_y) - trk[1]);
               for (int i = 0; i < 4; i++)
                  trk[i] = clamp32(longint'(trk[i]) + qmul(gn[i*2], e0)
                                   + qmul(gn[i*2+1], e1));
               for (int i = 0; i < 4; i++)
                  for (int j = 0; j < 4; j++)
                     np[i*4+j] = clamp32(longint'(cov[i*4+j]) - qmul(gn[i*2], cov[j])
                                         - qmul(gn[i*2+1], cov[4+j]));
               cov = np;
            end
         end
         default: ;
      endcase
      if (w.opcode == OP_UPDATE) begin
         if (sing) updates_sing++;
         else updates_ok++;
      end
      r.pos_x = trk[0];
      r.pos_y = trk[1];
      r.singular = sing;
   endtask

   // driver: predicts at acceptance
   always @(negedge clock) begin
      rsp_type exp_word;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready_q) begin
            filter_step(req_data, exp_word);
            expected_pos.push_back(exp_word);
            void'(pending_words.pop_front());
         end
         if ((req_valid && !req_ready_q) ) begin
            // hold
         end else if (pending_words.size() > (req_valid && req_ready_q ? 0 : 0) &&
                      !csr_busy && (!idle_on || $urandom_range(99) >= 38)) begin
            req_valid <= 1'b1;
            req_data  <= pending_words[0];
         end else begin
            req_valid <= 1'b0;
         end
         rsp_ready <= !idle_on || $urandom_range(99) >= 38;
      end
   end

   // acceptance seen at the rising edge
   always @(posedge clock) req_ready_q <= req_valid && req_ready;

   // monitor
   always @(posedge clock) begin
      rsp_type exp_word;
      if (!reset) begin
         cycles <= cycles + 1;
         if (rsp_valid && rsp_ready) begin
            results_seen <= results_seen + 1;
            if (expected_pos.size() == 0) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10) $display("unexpected result word %h", rsp_data);
            end else begin
               exp_word = expected_pos.pop_front();
               if (rsp_data.pos_x !== exp_word.pos_x || rsp_data.pos_y !== exp_word.pos_y ||
                   rsp_data.singular !== exp_word.singular) begin
                  mismatches = mismatches + 1;
                  if (mismatches <= 10)
                     $display("mismatch: expected x=%h y=%h sing=%b, got x=%h y=%h sing=%b",
                              exp_word.pos_x, exp_word.pos_y, exp_word.singular,
                              rsp_data.pos_x, rsp_data.pos_y, rsp_data.singular);
               end
            end
         end
         if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench NOT OK");
            $finish;
         end
      end
   end

   function automatic req_type make_word(logic [1:0] op, int signed x, int signed y);
      req_type w;
      w.opcode = op;
      w.meas_x = x;
      w.meas_y = y;
      return w;
   endfunction

   function automatic int signed rand_meas();
      case ($urandom_range(5))
         0: return $urandom;
         1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
         default: return int'($urandom_range(20 << 16)) - (10 << 16);
      endcase
   endfunction

   task automatic wait_idle();
      while (pending_words.size() != 0 || req_valid || expected_pos.size() != 0)
         @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [DW-1:0] val);
      csr_busy = 1'b1;
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_Q_DIAG: q_val = val[CSR_W-1:0];
         CSR_R_DIAG: r_val = val[CSR_W-1:0];
         CSR_P_INIT: p_val = val[CSR_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
      csr_busy = 1'b0;
   endtask

   // a track: init, then predict/update pairs with noisy measurements or random words
   task automatic queue_track(int len);
      int signed px, py;
      px = int'($urandom_range(200 << 16)) - (100 << 16);
      py = int'($urandom_range(200 << 16)) - (100 << 16);
      pending_words.push_back(make_word(OP_INIT, px, py));
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(9) == 0) begin
            pending_words.push_back(make_word(2'($urandom_range(3)), rand_meas(),
                                              rand_meas()));
         end else begin
            pending_words.push_back(make_word(OP_PREDICT, $urandom, $urandom));
            px += int'($urandom_range(1 << 16)) - (1 << 15);
            py += int'($urandom_range(1 << 16)) - (1 << 15);
            pending_words.push_back(make_word(OP_UPDATE,
                                    px + int'($urandom_range(1 << 14)),
                                    py - int'($urandom_range(1 << 14))));
         end
      end
   endtask

   initial begin
      logic [DW-1:0] cfg [3][5];
      mismatches = 0;
      results_seen = 0;
      cycles = 0;
      updates_ok = 0;
      updates_sing = 0;
      idle_on = 1'b1;
      csr_busy = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      filter_reset();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset state, extremes, unused opcode, singular updates
      pending_words.push_back(make_word(OP_PREDICT, 0, 0));
      pending_words.push_back(make_word(OP_UPDATE, 32'sh7fffffff, 32'sh80000000));
      pending_words.push_back(make_word(OP_UNUSED, 32'sh80000000, 32'sh7fffffff));
      pending_words.push_back(make_word(OP_INIT, 32'sh7fffffff, 32'sh80000000));
      pending_words.push_back(make_word(OP_PREDICT, -1, -1));
      pending_words.push_back(make_word(OP_UPDATE, 32'sh80000000, 32'sh7fffffff));
      pending_words.push_back(make_word(OP_UPDATE, -1, 0));
      pending_words.push_back(make_word(OP_INIT, 0, 0));
      for (int i = 0; i < 4; i++) pending_words.push_back(make_word(OP_PREDICT, 0, 0));
      pending_words.push_back(make_word(OP_UPDATE, 1 << 16, -(1 << 16)));
      wait_idle();
      // zero covariance and noise: determinant zero
      csr_write(CSR_P_INIT, 32'd0);
      csr_write(CSR_R_DIAG, 32'd0);
      csr_write(CSR_Q_DIAG, 32'd0);
      pending_words.push_back(make_word(OP_INIT, 5 << 16, 6 << 16));
      pending_words.push_back(make_word(OP_UPDATE, 7 << 16, 8 << 16));
      pending_words.push_back(make_word(OP_PREDICT, 0, 0));
      pending_words.push_back(make_word(OP_UPDATE, 7 << 16, 8 << 16));
      wait_idle();
      // saturating covariance
      csr_write(CSR_P_INIT, 32'hffffffff);
      csr_write(CSR_R_DIAG, 32'h7fffffff);
      csr_write(CSR_Q_DIAG, 32'h7fffffff);
      pending_words.push_back(make_word(OP_INIT, -3 << 16, 3 << 16));
      pending_words.push_back(make_word(OP_PREDICT, 0, 0));
      pending_words.push_back(make_word(OP_UPDATE, 1 << 16, 1 << 16));
      pending_words.push_back(make_word(OP_PREDICT, 0, 0));
      pending_words.push_back(make_word(OP_UPDATE, -(1 << 16), 2 << 16));
      wait_idle();

      // random phases over several register settings
      cfg = '{'{Q_RESET, 32'd0, 32'd1, 32'h7fffffff, 32'd6554},
              '{R_RESET, 32'd1, 32'd65536, 32'h7fffffff, 32'd0},
              '{P_RESET, 32'd0, 32'h7fffffff, 32'd1 << 20, 32'd100}};
      for (int ph = 0; ph < 10; ph++) begin
         idle_on = (ph != 4);
         if (ph < 5) begin
            csr_write(CSR_Q_DIAG, cfg[0][ph]);
            csr_write(CSR_R_DIAG, cfg[1][ph]);
            csr_write(CSR_P_INIT, cfg[2][ph]);
         end else begin
            csr_write(CSR_Q_DIAG, $urandom_range(1) ? $urandom : $urandom_range(2000));
            csr_write(CSR_R_DIAG, $urandom_range(1) ? $urandom : $urandom_range(5000));
            csr_write(CSR_P_INIT, $urandom_range(1) ? $urandom : $urandom_range(1 << 18));
         end
         csr_write(CSR_UNUSED, $urandom);
         while (pending_words.size() < 170) queue_track($urandom_range(3, 12));
         wait_idle();
      end
      idle_on = 1'b1;

      $display("covered %0d result words: %0d regular and %0d singular updates",
               results_seen, updates_ok, updates_sing);
      if (mismatches == 0) begin
         $display("testbench OK");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("testbench NOT OK");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/kcv_pkg.sv
rtl/kcv_div.sv
rtl/kcv_dp.sv
rtl/kcv_ctrl.sv
rtl/kalman_cv_tracker_2d.sv
tb/testbench.sv
